FILE: rtl/core/pce_pkg.sv
// Shared constants, codes, command/status types and the multiply schedule of the spline evaluator.
`timescale 1ns / 1ps

package pce_pkg;

  // Default configuration of the block.
  localparam int unsigned MAX_POINTS_DEF = 256;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // Fixed field widths.
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned COUNT_W   = 9;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned CFG_IDX_W = 1;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_WRITE_A   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE_BCD = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ      = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_VALUE     = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_SLOPE     = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE   = 1'b1;

  // Saturation limits.
  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  // Operand pairs of the shared multiplier.
  typedef enum logic [2:0] {
    MUL_FF,
    MUL_F2F,
    MUL_BF,
    MUL_CF2,
    MUL_DF3,
    MUL_C2F,
    MUL_D3F2
  } mul_sel_e;

  // Where a finished product goes in the following cycle.
  typedef enum logic [1:0] {
    DST_NONE,
    DST_F2,
    DST_F3,
    DST_ACC
  } dst_e;

  // How an evaluation finishes.
  typedef enum logic [1:0] {
    EVAL_ZERO,
    EVAL_A,
    EVAL_FULL
  } eval_kind_e;

  // Read address source.
  typedef enum logic {
    RD_INDEX,
    RD_SEG
  } rd_sel_e;

  typedef struct packed {
    mul_sel_e sel;
    dst_e     dst;
    logic     last;
  } mul_step_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     clr_en;
    logic     load;
    logic     wr_en;
    logic     rd_en;
    rd_sel_e  rd_sel;
    logic     div_start;
    logic     div_step;
    logic     seg_load;
    logic     acc_init;
    logic     mul_en;
    mul_sel_e mul_sel;
    dst_e     mul_dst;
    logic     res_load;
  } pce_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic              clr_done;
    logic              div_done;
    logic [FUNC_W-1:0] func;
    logic              loop;
    logic              empty;
    eval_kind_e        kind;
    logic              out_free;
  } pce_stat_t;

  // Power-sum schedule: each power of the fraction is formed as it is needed, each term added as it lands.
  function automatic mul_step_t mul_plan(input logic slope, input logic [2:0] step);
    mul_step_t s;
    s.sel  = MUL_FF;
    s.dst  = DST_NONE;
    s.last = 1'b1;
    if (slope) begin
      case (step)
        3'd0: begin s.sel = MUL_FF;   s.dst = DST_F2;  s.last = 1'b0; end
        3'd1: begin s.sel = MUL_C2F;  s.dst = DST_ACC; s.last = 1'b0; end
        3'd2: begin s.sel = MUL_D3F2; s.dst = DST_ACC; s.last = 1'b1; end
        default: begin s.sel = MUL_FF; s.dst = DST_NONE; s.last = 1'b1; end
      endcase
    end else begin
      case (step)
        3'd0: begin s.sel = MUL_FF;  s.dst = DST_F2;  s.last = 1'b0; end
        3'd1: begin s.sel = MUL_BF;  s.dst = DST_ACC; s.last = 1'b0; end
        3'd2: begin s.sel = MUL_F2F; s.dst = DST_F3;  s.last = 1'b0; end
        3'd3: begin s.sel = MUL_CF2; s.dst = DST_ACC; s.last = 1'b0; end
        3'd4: begin s.sel = MUL_DF3; s.dst = DST_ACC; s.last = 1'b1; end
        default: begin s.sel = MUL_FF; s.dst = DST_NONE; s.last = 1'b1; end
      endcase
    end
    return s;
  endfunction

endpackage

FILE: rtl/core/pce_if.sv
// Valid/ready channel interfaces for the request and result beats.
`timescale 1ns / 1ps

interface pce_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic [7:0]         seg_index;
  logic signed [31:0] value_a;
  logic signed [31:0] coef_b_in;
  logic signed [31:0] coef_c_in;
  logic signed [31:0] coef_d_in;
  logic signed [31:0] position;

  modport source (
    output valid, func, seg_index, value_a, coef_b_in, coef_c_in, coef_d_in, position,
    input  ready
  );
  modport sink (
    input  valid, func, seg_index, value_a, coef_b_in, coef_c_in, coef_d_in, position,
    output ready
  );
endinterface

interface pce_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic signed [31:0] coef_b_out;
  logic signed [31:0] coef_c_out;
  logic signed [31:0] coef_d_out;
  logic               status;

  modport source (
    output valid, result_value, coef_b_out, coef_c_out, coef_d_out, status,
    input  ready
  );
  modport sink (
    input  valid, result_value, coef_b_out, coef_c_out, coef_d_out, status,
    output ready
  );
endinterface

FILE: rtl/core/piecewise_cubic_evaluator.sv
// Top level of the piecewise cubic spline evaluator.
//
//   channel   dir   handshake          payload
//   in_i      in    valid/ready        func, seg_index, value_a, coef_b/c/d_in, position
//   out_o     out   valid/ready        result_value, coef_b/c/d_out, status
//   cfg       in    cfg_we_i           cfg_idx_i, cfg_data_i (point_count, loop_mode)
//
// One beat is worked on at a time. A value takes five passes and a slope three through the
// one shared multiplier, which follow the table read. Loop mode first runs the modulo unit,
// which resolves one bit of the segment remainder per cycle.
// After reset the tables are cleared while in_i.ready stays low.
// A result waits in its output register; a new beat is accepted meanwhile.
`timescale 1ns / 1ps

module piecewise_cubic_evaluator
  import pce_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COUNT_W-1:0]   cfg_data_i,
  pce_in_if.sink               in_i,
  pce_out_if.source            out_o
);

  pce_cmd_t  cmd;
  pce_stat_t stat;

  pce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pce_dp #(
    .MAX_POINTS (MAX_POINTS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .func_i         (in_i.func),
    .seg_index_i    (in_i.seg_index),
    .value_a_i      (in_i.value_a),
    .coef_b_i       (in_i.coef_b_in),
    .coef_c_i       (in_i.coef_c_in),
    .coef_d_i       (in_i.coef_d_in),
    .position_i     (in_i.position),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .result_value_o (out_o.result_value),
    .coef_b_o       (out_o.coef_b_out),
    .coef_c_o       (out_o.coef_c_out),
    .coef_d_o       (out_o.coef_d_out),
    .status_o       (out_o.status)
  );

  // One beat at a time: ready drops after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted while a beat is still in work");

  // A result is loaded only into a free output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_load |-> stat.out_free)
    else $error("result overwrote a waiting beat");

  // The clearing sweep never overlaps a table write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.clr_en && cmd.wr_en))
    else $error("table write during clearing sweep");

  // Output valid rises only after a result load.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.res_load))
    else $error("output valid without a result");

endmodule

FILE: rtl/core/pce_ctrl.sv
// Controller state machine that sequences clearing, table access and the multiply schedule.
`timescale 1ns / 1ps

module pce_ctrl
  import pce_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pce_stat_t stat_i,
  output pce_cmd_t  cmd_o
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_SEG    = 4'd4;
  localparam logic [3:0] S_READ   = 4'd5;
  localparam logic [3:0] S_INIT   = 4'd6;
  localparam logic [3:0] S_MUL    = 4'd7;
  localparam logic [3:0] S_DRAIN  = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state_q, state_d;
  logic [2:0] step_q, step_d;
  mul_step_t  plan;

  assign plan = mul_plan(stat_i.func == FUNC_SLOPE, step_q);

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat_i.func) inside
          FUNC_WRITE_A, FUNC_WRITE_BCD: begin
            cmd_o.wr_en = 1'b1;
            state_d     = S_DONE;
          end
          FUNC_READ: begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_INDEX;
            state_d      = S_DONE;
          end
          FUNC_VALUE, FUNC_SLOPE: begin
            if (stat_i.loop && !stat_i.empty) begin
              cmd_o.div_start = 1'b1;
              state_d         = S_DIV;
            end else begin
              state_d = S_SEG;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_DIV: begin
        if (stat_i.div_done) state_d = S_SEG;
        else cmd_o.div_step = 1'b1;
      end
      S_SEG: begin
        cmd_o.seg_load = 1'b1;
        state_d        = S_READ;
      end
      S_READ: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_SEG;
        state_d      = (stat_i.kind == EVAL_FULL) ? S_INIT : S_DONE;
      end
      S_INIT: begin
        cmd_o.acc_init = 1'b1;
        step_d         = '0;
        state_d        = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = plan.sel;
        cmd_o.mul_dst = plan.dst;
        if (plan.last) state_d = S_DRAIN;
        else step_d = step_q + 3'd1;
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

FILE: rtl/core/pce_dp.sv
// Datapath: coefficient memories, segment finder, modulo unit, shared multiplier and result register.
`timescale 1ns / 1ps

module pce_dp
  import pce_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [COUNT_W-1:0]       cfg_data_i,
  input  logic [FUNC_W-1:0]        func_i,
  input  logic [IDX_W-1:0]         seg_index_i,
  input  logic signed [DATA_W-1:0] value_a_i,
  input  logic signed [DATA_W-1:0] coef_b_i,
  input  logic signed [DATA_W-1:0] coef_c_i,
  input  logic signed [DATA_W-1:0] coef_d_i,
  input  logic signed [DATA_W-1:0] position_i,
  input  pce_cmd_t                 cmd_i,
  output pce_stat_t                stat_o,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic signed [DATA_W-1:0] result_value_o,
  output logic signed [DATA_W-1:0] coef_b_o,
  output logic signed [DATA_W-1:0] coef_c_o,
  output logic signed [DATA_W-1:0] coef_d_o,
  output logic                     status_o
);

  localparam int unsigned AW   = $clog2(MAX_POINTS);
  localparam int unsigned CW   = $clog2(MAX_POINTS + 1);
  localparam int unsigned NW   = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int unsigned KW   = (CW > IDX_W) ? CW : IDX_W;
  localparam int unsigned TW   = DATA_W - FRAC_BITS;
  localparam int unsigned FW   = FRAC_BITS + 1;
  localparam int unsigned OW   = DATA_W + 2;
  localparam int unsigned PW   = OW + FW;
  localparam int unsigned ACW  = DATA_W + 8;
  localparam int unsigned EW   = ((TW > CW) ? TW : CW) + 2;
  localparam int unsigned DCW  = $clog2(TW + 1);
  localparam int unsigned BCDW = 3 * DATA_W;

  // Configuration registers.
  logic [COUNT_W-1:0] point_count_q;
  logic               loop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= '0;
      loop_q        <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POINT_COUNT: point_count_q <= cfg_data_i;
        CFG_LOOP_MODE:   loop_q        <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Active point count, capped at the table depth.
  logic [NW-1:0] pc_ext;
  logic [CW-1:0] n;
  logic          ok;

  assign pc_ext = NW'(point_count_q);
  assign n      = (pc_ext > NW'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(pc_ext);

  // Request beat capture.
  logic [FUNC_W-1:0]        func_q;
  logic [IDX_W-1:0]         idx_q;
  logic signed [DATA_W-1:0] a_in_q, b_in_q, c_in_q, d_in_q, pos_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      idx_q  <= seg_index_i;
      a_in_q <= value_a_i;
      b_in_q <= coef_b_i;
      c_in_q <= coef_c_i;
      d_in_q <= coef_d_i;
      pos_q  <= position_i;
    end
  end

  assign ok = KW'(idx_q) < KW'(n);

  // Clearing sweep after reset.
  logic [AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_cnt_q <= '0;
    else if (cmd_i.clr_en) clr_cnt_q <= clr_cnt_q + 1'b1;
  end

  // Coefficient memories: a in one, b/c/d side by side in the other.
  logic [DATA_W-1:0] mem_a   [MAX_POINTS];
  logic [BCDW-1:0]   mem_bcd [MAX_POINTS];
  logic [DATA_W-1:0] rd_a_q;
  logic [BCDW-1:0]   rd_bcd_q;
  logic [AW-1:0]     addr_idx, seg_q, rd_addr;

  assign addr_idx = AW'(idx_q);
  assign rd_addr  = (cmd_i.rd_sel == RD_SEG) ? seg_q : addr_idx;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      mem_a[clr_cnt_q] <= '0;
    end else if (cmd_i.wr_en && ok && (func_q == FUNC_WRITE_A)) begin
      mem_a[addr_idx] <= a_in_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      mem_bcd[clr_cnt_q] <= '0;
    end else if (cmd_i.wr_en && ok && (func_q == FUNC_WRITE_BCD)) begin
      mem_bcd[addr_idx] <= {b_in_q, c_in_q, d_in_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_a_q   <= mem_a[rd_addr];
      rd_bcd_q <= mem_bcd[rd_addr];
    end
  end

  // Integer and fraction parts of the position.
  logic signed [TW-1:0]   ti;
  logic [FRAC_BITS-1:0]   frac;
  logic [TW-1:0]          mag;

  assign ti   = pos_q[DATA_W-1:FRAC_BITS];
  assign frac = pos_q[FRAC_BITS-1:0];
  assign mag  = ti[TW-1] ? TW'(-ti) : TW'(ti);

  // Restoring modulo unit: one bit of the integer part per cycle.
  logic [TW-1:0]  m_q;
  logic [CW-1:0]  rem_q;
  logic           neg_q;
  logic [DCW-1:0] div_cnt_q;
  logic [CW:0]    rem_shift, rem_next;

  assign rem_shift = {rem_q, m_q[TW-1]};
  assign rem_next  = (rem_shift >= {1'b0, n}) ? (rem_shift - {1'b0, n}) : rem_shift;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      m_q   <= mag;
      rem_q <= '0;
      neg_q <= ti[TW-1];
    end else if (cmd_i.div_step) begin
      m_q   <= {m_q[TW-2:0], 1'b0};
      rem_q <= rem_next[CW-1:0];
    end
  end

  // Segment selection for loop and clamp modes.
  logic [CW-1:0]          lseg, nm1;
  logic                   round_up, slope;
  logic signed [EW-1:0]   tidx, nlast;
  logic [AW-1:0]          seg_d;
  logic signed [FW-1:0]   f_d, f_q;
  eval_kind_e             kind_d, kind_q;

  assign slope    = (func_q == FUNC_SLOPE);
  assign nm1      = n - 1'b1;
  assign lseg     = (neg_q && (rem_q != '0)) ? (n - rem_q) : rem_q;
  assign round_up = pos_q[DATA_W-1] && (frac != '0);
  assign tidx     = {{(EW-TW){ti[TW-1]}}, ti} + EW'(round_up);
  assign nlast    = $signed({{(EW-CW){1'b0}}, nm1});

  always_comb begin
    seg_d  = '0;
    f_d    = $signed({1'b0, frac});
    kind_d = EVAL_FULL;
    if (n == '0) begin
      kind_d = EVAL_ZERO;
    end else if (loop_q) begin
      seg_d = AW'(lseg);
    end else begin
      if (round_up) f_d = $signed({1'b1, frac});
      if (!slope) begin
        if (tidx <= 0) begin
          kind_d = EVAL_A;
        end else if (tidx >= nlast) begin
          kind_d = EVAL_A;
          seg_d  = AW'(nm1);
        end else begin
          seg_d = AW'(tidx);
        end
      end else begin
        if ((tidx < 0) || (tidx >= nlast)) kind_d = EVAL_ZERO;
        else seg_d = AW'(tidx);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.seg_load) begin
      seg_q  <= seg_d;
      f_q    <= f_d;
      kind_q <= kind_d;
    end
  end

  // Shared multiplier with its operand selection.
  logic signed [DATA_W-1:0] a_s, b_s, c_s, d_s;
  logic signed [OW-1:0]     opa;
  logic signed [FW-1:0]     opb, f2_q, f3_q;
  logic signed [PW-1:0]     prod_q, prod_sh;
  logic signed [ACW-1:0]    acc_q;
  dst_e                     pdst_q;

  assign a_s = rd_a_q;
  assign b_s = rd_bcd_q[BCDW-1 -: DATA_W];
  assign c_s = rd_bcd_q[2*DATA_W-1 -: DATA_W];
  assign d_s = rd_bcd_q[DATA_W-1:0];

  always_comb begin
    opa = OW'(f_q);
    opb = f_q;
    case (cmd_i.mul_sel)
      MUL_FF:   begin opa = OW'(f_q);  opb = f_q;  end
      MUL_F2F:  begin opa = OW'(f2_q); opb = f_q;  end
      MUL_BF:   begin opa = OW'(b_s);  opb = f_q;  end
      MUL_CF2:  begin opa = OW'(c_s);  opb = f2_q; end
      MUL_DF3:  begin opa = OW'(d_s);  opb = f3_q; end
      MUL_C2F:  begin opa = OW'(c_s) + OW'(c_s); opb = f_q; end
      MUL_D3F2: begin opa = OW'(d_s) + OW'(d_s) + OW'(d_s); opb = f2_q; end
      default:  begin opa = OW'(f_q);  opb = f_q;  end
    endcase
  end

  assign prod_sh = prod_q >>> FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pdst_q <= DST_NONE;
    else pdst_q <= cmd_i.mul_en ? cmd_i.mul_dst : DST_NONE;
  end

  // Product register, powers of the fraction and the exact accumulator.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) prod_q <= PW'(opa) * PW'(opb);
    if (pdst_q == DST_F2) f2_q <= FW'(prod_sh);
    if (pdst_q == DST_F3) f3_q <= FW'(prod_sh);
    if (cmd_i.acc_init) begin
      acc_q <= slope ? ACW'(b_s) : ACW'(a_s);
    end else if (pdst_q == DST_ACC) begin
      acc_q <= acc_q + ACW'(prod_sh);
    end
  end

  // Saturate the sum to 32 bits.
  logic [DATA_W-1:0] sat;

  always_comb begin
    if ((acc_q[ACW-1:DATA_W-1] == '0) || (acc_q[ACW-1:DATA_W-1] == '1)) begin
      sat = acc_q[DATA_W-1:0];
    end else begin
      sat = acc_q[ACW-1] ? SAT_MIN : SAT_MAX;
    end
  end

  // Result beat contents.
  logic [DATA_W-1:0] res_d, b_d, c_d, d_d;
  logic              st_d;

  always_comb begin
    res_d = '0;
    b_d   = '0;
    c_d   = '0;
    d_d   = '0;
    st_d  = 1'b0;
    case (func_q) inside
      FUNC_WRITE_A, FUNC_WRITE_BCD: st_d = !ok;
      FUNC_READ: begin
        st_d = !ok;
        if (ok) begin
          b_d = b_s;
          c_d = c_s;
          d_d = d_s;
        end
      end
      FUNC_VALUE, FUNC_SLOPE: begin
        case (kind_q)
          EVAL_A:    res_d = a_s;
          EVAL_FULL: res_d = sat;
          default:   res_d = '0;
        endcase
      end
      default: ;
    endcase
  end

  // Output register; the next beat can be taken while this one waits.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.res_load) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      result_value_o <= res_d;
      coef_b_o       <= b_d;
      coef_c_o       <= c_d;
      coef_d_o       <= d_d;
      status_o       <= st_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // Status toward the controller.
  assign stat_o.clr_done = (clr_cnt_q == AW'(MAX_POINTS - 1));
  assign stat_o.div_done = (div_cnt_q == DCW'(TW));
  assign stat_o.func     = func_q;
  assign stat_o.loop     = loop_q;
  assign stat_o.empty    = (n == '0);
  assign stat_o.kind     = kind_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

endmodule

FILE: dv/piecewise_cubic_evaluator_tb.sv
// Self-checking testbench of the piecewise cubic spline evaluator with its own fixed-point predictor.
`timescale 1ns / 1ps

module piecewise_cubic_evaluator_tb;
  import pce_pkg::*;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int          IDLE_LIMIT  = 20000;
  localparam int          DRAIN_WAIT  = 60;

  // One expected result beat.
  typedef struct {
    logic [31:0] value;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic        status;
  } spline_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [COUNT_W-1:0]   cfg_data_i;

  pce_in_if  req_if ();
  pce_out_if rsp_if ();

  piecewise_cubic_evaluator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (req_if),
    .out_o      (rsp_if)
  );

  // Predictor copy of the coefficient tables and registers.
  logic [31:0] seg_a [TABLE_DEPTH];
  logic [31:0] seg_b [TABLE_DEPTH];
  logic [31:0] seg_c [TABLE_DEPTH];
  logic [31:0] seg_d [TABLE_DEPTH];
  logic [8:0]  pred_count;
  logic        pred_loop;

  spline_result_t pending_results[$];
  int errors = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  // Number of segments that are actually in use.
  function automatic int unsigned used_points();
    return (pred_count > TABLE_DEPTH) ? TABLE_DEPTH : pred_count;
  endfunction

  // Exact product shifted right by the fraction width, rounding toward minus infinity.
  function automatic longint fx_mul(longint x, longint y);
    return (x * y) >>> FRAC_BITS_DEF;
  endfunction

  // Value or slope of the spline at one position.
  function automatic logic [31:0] spline_at(longint t, bit slope);
    int unsigned n;
    longint one;
    longint span;
    longint w;
    longint seg;
    longint f;
    longint f2;
    longint f3;
    longint b;
    longint c;
    longint d;
    longint sum;
    int unsigned p;
    n = used_points();
    one = longint'(1) <<< FRAC_BITS_DEF;
    if (n == 0) return '0;
    if (pred_loop) begin
      span = longint'(n) * one;
      w = t % span;
      if (w < 0) w += span;
      seg = w / one;
      f = w - seg * one;
    end else begin
      seg = t / one;
      f = t - seg * one;
      if (!slope) begin
        if (seg <= 0) return seg_a[0];
        if (seg >= longint'(n) - 1) return seg_a[n-1];
      end else if (seg < 0 || seg >= longint'(n) - 1) begin
        return '0;
      end
    end
    p = int'(seg);
    if (p >= n) p = n - 1;
    b = longint'($signed(seg_b[p]));
    c = longint'($signed(seg_c[p]));
    d = longint'($signed(seg_d[p]));
    f2 = fx_mul(f, f);
    if (slope) begin
      sum = b + fx_mul(2 * c, f) + fx_mul(3 * d, f2);
    end else begin
      f3 = fx_mul(f2, f);
      sum = longint'($signed(seg_a[p])) + fx_mul(b, f) + fx_mul(c, f2) + fx_mul(d, f3);
    end
    if (sum > 64'sd2147483647) return SAT_MAX;
    if (sum < -64'sd2147483648) return SAT_MIN;
    return sum[31:0];
  endfunction

  // Applies one request to the predictor and returns the beat it must produce.
  function automatic spline_result_t apply_request(logic [2:0] func, logic [7:0] idx,
                                                   logic [31:0] a, logic [31:0] b,
                                                   logic [31:0] c, logic [31:0] d,
                                                   logic [31:0] pos);
    spline_result_t r;
    bit ok;
    r = '{default: '0};
    ok = idx < used_points();
    case (func)
      FUNC_WRITE_A: begin
        if (ok) seg_a[idx] = a;
        r.status = !ok;
      end
      FUNC_WRITE_BCD: begin
        if (ok) begin
          seg_b[idx] = b;
          seg_c[idx] = c;
          seg_d[idx] = d;
        end
        r.status = !ok;
      end
      FUNC_READ: begin
        if (ok) begin
          r.b = seg_b[idx];
          r.c = seg_c[idx];
          r.d = seg_d[idx];
        end
        r.status = !ok;
      end
      FUNC_VALUE: r.value = spline_at(longint'($signed(pos)), 1'b0);
      FUNC_SLOPE: r.value = spline_at(longint'($signed(pos)), 1'b1);
      default: ;
    endcase
    return r;
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sends one request beat and records what it must produce.
  task automatic send_req(logic [2:0] func, logic [7:0] idx, logic [31:0] a,
                          logic [31:0] b, logic [31:0] c, logic [31:0] d,
                          logic [31:0] pos);
    int gap;
    req_if.valid       <= 1'b1;
    req_if.func        <= func;
    req_if.seg_index   <= idx;
    req_if.value_a     <= a;
    req_if.coef_b_in   <= b;
    req_if.coef_c_in   <= c;
    req_if.coef_d_in   <= d;
    req_if.position    <= pos;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pending_results.insert(pending_results.size(), apply_request(func, idx, a, b, c, d, pos));
    beats_sent++;
    gap = gap_len();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Holds the sender until every expected beat has come back and the block is idle.
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Writes one register while the block is idle.
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] data);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_POINT_COUNT) pred_count = data;
    else pred_loop = data[0];
  endtask

  task automatic set_mode(int unsigned count, bit loop);
    write_cfg(CFG_POINT_COUNT, count[COUNT_W-1:0]);
    write_cfg(CFG_LOOP_MODE, COUNT_W'(loop));
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH beat %0d %s: got %h expected %h", beats_checked, what, got, want);
  endtask

  // Coefficient with a random magnitude, full width now and then.
  function automatic logic [31:0] rand_coef();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return $signed($urandom()) >>> $urandom_range(4, 20);
  endfunction

  // Position near the table, occasionally anywhere.
  function automatic logic [31:0] rand_pos();
    int unsigned n;
    logic [31:0] p;
    n = used_points();
    if ($urandom_range(0, 9) == 0) return $urandom();
    p = {16'($urandom_range(0, n + 1)), 16'($urandom())};
    if ($urandom_range(0, 4) == 0) p = -p;
    return p;
  endfunction

  function automatic logic [7:0] rand_idx();
    int unsigned n;
    n = used_points();
    if (n > 0 && $urandom_range(0, 99) < 88) return 8'($urandom_range(0, n - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  // Result side: random stalls and in-order comparison.
  always @(posedge clk_i) begin
    spline_result_t want;
    if (rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", rsp_if.result_value, '0);
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.result_value !== want.value)
          report_mismatch("result_value", rsp_if.result_value, want.value);
        if (rsp_if.coef_b_out !== want.b) report_mismatch("coef_b_out", rsp_if.coef_b_out, want.b);
        if (rsp_if.coef_c_out !== want.c) report_mismatch("coef_c_out", rsp_if.coef_c_out, want.c);
        if (rsp_if.coef_d_out !== want.d) report_mismatch("coef_d_out", rsp_if.coef_d_out, want.d);
        if (rsp_if.status !== want.status)
          report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
      end
      beats_checked++;
    end
  end

  int ready_hold = 0;
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      rsp_if.ready <= 1'b0;
    end else if (gap_len() > 0 && $urandom_range(0, 1) == 0) begin
      ready_hold <= gap_len();
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // Watchdog on cycles with no beat accepted on either channel.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Empty table: every operation flags or returns zero.
  task automatic test_empty_table();
    logic [2:0] fn;
    for (int k = 0; k < 8; k++) begin
      fn = k[2:0];
      send_req(fn, (k % 2) ? 8'hFF : 8'h00, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
               32'h0000_0001, (k % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF);
    end
  endtask

  // Extremes, clamping, negative fractions, bad indexes, unused codes and saturation on a short table, then wrap mode.
  task automatic test_directed_edges();
    set_mode(4, 1'b0);
    send_req(FUNC_WRITE_A, 0, 32'h0001_0000, '0, '0, '0, '0);
    send_req(FUNC_WRITE_A, 3, 32'h8000_0000, '0, '0, '0, '0);
    send_req(FUNC_WRITE_BCD, 0, '0, 32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000, '0);
    send_req(FUNC_WRITE_BCD, 1, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
    send_req(FUNC_WRITE_A, 1, 32'h7FFF_FFFF, '0, '0, '0, '0);
    send_req(FUNC_WRITE_BCD, 2, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0);
    send_req(FUNC_WRITE_A, 4, 32'h1234_5678, '0, '0, '0, '0);
    send_req(FUNC_READ, 1, '0, '0, '0, '0, '0);
    send_req(FUNC_READ, 255, '0, '0, '0, '0, '0);
    send_req(FUNC_VALUE, 0, '0, '0, '0, '0, 32'hFFFE_8000);
    send_req(FUNC_VALUE, 0, '0, '0, '0, '0, 32'hFFFF_8000);
    send_req(FUNC_VALUE, 0, '0, '0, '0, '0, 32'h0001_FFFF);
    send_req(FUNC_VALUE, 0, '0, '0, '0, '0, 32'h0002_C000);
    send_req(FUNC_VALUE, 0, '0, '0, '0, '0, 32'h0003_0000);
    send_req(FUNC_SLOPE, 0, '0, '0, '0, '0, 32'hFFFF_8000);
    send_req(FUNC_SLOPE, 0, '0, '0, '0, '0, 32'hFFFE_8000);
    send_req(FUNC_SLOPE, 0, '0, '0, '0, '0, 32'h0001_8000);
    send_req(FUNC_SLOPE, 0, '0, '0, '0, '0, 32'h0002_8000);
    send_req(FUNC_SLOPE, 0, '0, '0, '0, '0, 32'h0003_0000);
    send_req(3'd5, 0, '0, '0, '0, '0, 32'h0000_8000);
    send_req(3'd6, 2, '0, '0, '0, '0, '0);
    set_mode(4, 1'b1);
    send_req(FUNC_VALUE, 0, '0, '0, '0, '0, 32'hFFFF_8000);
    send_req(FUNC_SLOPE, 0, '0, '0, '0, '0, 32'h8000_0000);
    send_req(FUNC_VALUE, 0, '0, '0, '0, '0, 32'h7FFF_FFFF);
    send_req(3'd7, 3, '0, '0, '0, '0, '0);
  endtask

  // Random traffic under one setting: fill up to 24 segments of the table, then mixed operations.
  task automatic test_random_phase(int unsigned count, bit loop, int beats);
    int unsigned n;
    int r;
    set_mode(count, loop);
    n = used_points();
    for (int s = 0; s < n && s < 24; s++) begin
      send_req(FUNC_WRITE_A, 8'(s), rand_coef(), '0, '0, '0, '0);
      send_req(FUNC_WRITE_BCD, 8'(s), '0, rand_coef(), rand_coef(), rand_coef(), '0);
    end
    for (int k = 0; k < beats; k++) begin
      r = $urandom_range(0, 99);
      if (k == beats / 2) drain();
      if (r < 15) send_req(FUNC_WRITE_A, rand_idx(), rand_coef(), $urandom(), $urandom(),
                           $urandom(), $urandom());
      else if (r < 30) send_req(FUNC_WRITE_BCD, rand_idx(), $urandom(), rand_coef(),
                                rand_coef(), rand_coef(), $urandom());
      else if (r < 40) send_req(FUNC_READ, rand_idx(), $urandom(), $urandom(), $urandom(),
                                $urandom(), $urandom());
      else if (r < 68) send_req(FUNC_VALUE, 8'($urandom()), $urandom(), $urandom(), $urandom(),
                                $urandom(), rand_pos());
      else if (r < 95) send_req(FUNC_SLOPE, 8'($urandom()), $urandom(), $urandom(), $urandom(),
                                $urandom(), rand_pos());
      else send_req(3'($urandom_range(5, 7)), 8'($urandom()), $urandom(), $urandom(),
                    $urandom(), $urandom(), $urandom());
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.func = '0;
    req_if.seg_index = '0;
    req_if.value_a = '0;
    req_if.coef_b_in = '0;
    req_if.coef_c_in = '0;
    req_if.coef_d_in = '0;
    req_if.position = '0;
    pred_count = '0;
    pred_loop = 1'b0;
    for (int s = 0; s < TABLE_DEPTH; s++) begin
      seg_a[s] = '0;
      seg_b[s] = '0;
      seg_c[s] = '0;
      seg_d[s] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_directed_edges();
    test_random_phase(256, 1'b0, 260);
    test_random_phase(1, 1'b1, 150);
    test_random_phase(2, 1'b0, 150);
    test_random_phase(300, 1'b1, 240);
    test_random_phase(511, 1'b0, 150);
    test_random_phase(0, 1'b1, 60);
    test_random_phase($urandom_range(3, 40), 1'b0, 240);
    test_random_phase($urandom_range(3, 40), 1'b1, 240);
    test_random_phase($urandom_range(41, 255), 1'($urandom_range(0, 1)), 200);

    drain();
    $display("Covered %0d request beats and %0d result beats over empty, short, full and",
             beats_sent, beats_checked);
    $display("oversized tables in clamp and wrap modes, with stalls on both channels.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
